// ===== hdl/dhcp_rfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhcp_rfp_pkg
// Types and constants for the DHCP client reply filter and option parser.
// ----------------------------------------------------------------------------
package dhcp_rfp_pkg;

	localparam int MAX_LEN  = 1536;
	localparam int HDR_LEN  = 240;
	localparam int OFFSET_W = 11;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic CFG_XID = 1'b0;
	localparam logic CFG_MAC = 1'b1;

	localparam logic [1:0] ST_REJECT  = 2'd0;
	localparam logic [1:0] ST_OFFER   = 2'd1;
	localparam logic [1:0] ST_ACK     = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam logic [7:0] BOOTREPLY   = 8'd2;
	localparam logic [7:0] COOKIE_0    = 8'h63;
	localparam logic [7:0] COOKIE_1    = 8'h82;
	localparam logic [7:0] COOKIE_2    = 8'h53;
	localparam logic [7:0] COOKIE_3    = 8'h63;

	localparam logic [7:0] OPT_PAD       = 8'd0;
	localparam logic [7:0] OPT_SUBNET    = 8'd1;
	localparam logic [7:0] OPT_ROUTER    = 8'd3;
	localparam logic [7:0] OPT_DNS       = 8'd6;
	localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
	localparam logic [7:0] OPT_SERVER_ID = 8'd54;
	localparam logic [7:0] OPT_END       = 8'd255;

	localparam logic [7:0] MSG_OFFER = 8'd2;
	localparam logic [7:0] MSG_ACK   = 8'd5;

	localparam int SLOT_SUBNET = 0;
	localparam int SLOT_ROUTER = 1;
	localparam int SLOT_DNS    = 2;
	localparam int SLOT_SERVER = 3;
	localparam int NUM_SLOTS   = 4;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_DATA,
		PH_DONE
	} opt_phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  message_type;
		logic [31:0] offered_ip;
		logic [31:0] subnet_mask;
		logic [31:0] router_ip;
		logic [31:0] dns_ip;
		logic [31:0] server_ip;
		logic        have_offer;
		logic        have_ack;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/dhcp_reply_filter_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhcp_reply_filter_parser_top
// Filters DHCP replies byte by byte, walks options and commits lease values.
// ----------------------------------------------------------------------------
// The accepted last byte enters the input register; the update stage then loads
// the result register. Throughput: 1 beat per cycle while no stalled result holds
// the input; one update stage writes parser state and result in the same cycle.
// Reset: arst_n clears parser state, lease registers, flags and config.
// ----------------------------------------------------------------------------
module dhcp_reply_filter_parser_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_index,
	input  wire logic [47:0]           cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire dhcp_rfp_pkg::item_t   item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output dhcp_rfp_pkg::result_t      result
);

	logic [31:0] xid_q;
	logic [47:0] mac_q;

	logic                 valid_s1;
	dhcp_rfp_pkg::item_t  item_s1;
	logic                 advance;

	logic [dhcp_rfp_pkg::OFFSET_W-1:0] offset_q;
	logic                      good_q;
	dhcp_rfp_pkg::opt_phase_t  phase_q;
	logic [7:0]                code_q;
	logic [7:0]                len_q;
	logic [7:0]                left_q;
	logic [31:0]               cap_q;
	logic [7:0]                ptype_q;
	logic [31:0]               yiaddr_q;
	logic [31:0]               pval_q [dhcp_rfp_pkg::NUM_SLOTS];
	logic [dhcp_rfp_pkg::NUM_SLOTS-1:0] pseen_q;
	logic [31:0]               lease_ip_q;
	logic [31:0]               lease_q [dhcp_rfp_pkg::NUM_SLOTS];
	logic                      offer_q;
	logic                      ack_q;

	logic [dhcp_rfp_pkg::OFFSET_W-1:0] offset_n;
	logic                      good_n;
	dhcp_rfp_pkg::opt_phase_t  phase_n;
	logic [7:0]                code_n;
	logic [7:0]                len_n;
	logic [7:0]                left_n;
	logic [31:0]               cap_n;
	logic [7:0]                ptype_n;
	logic [31:0]               yiaddr_n;
	logic [31:0]               pval_n [dhcp_rfp_pkg::NUM_SLOTS];
	logic [dhcp_rfp_pkg::NUM_SLOTS-1:0] pseen_n;
	logic [31:0]               lease_ip_n;
	logic [31:0]               lease_n [dhcp_rfp_pkg::NUM_SLOTS];
	logic                      offer_n;
	logic                      ack_n;

	logic                      result_valid_q;
	dhcp_rfp_pkg::result_t     result_q;
	logic                      result_load;
	dhcp_rfp_pkg::result_t     result_n;

	logic [dhcp_rfp_pkg::OFFSET_W-1:0] pos;
	logic [7:0]  b;
	logic [7:0]  want;
	logic        checked;
	logic [2:0]  mac_idx;
	logic [7:0]  idx;
	logic        finish;
	logic        is_byte;

	assign item_stall   = valid_s1 && result_valid_q && result_stall;
	assign advance      = valid_s1 && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign pos     = offset_q;
	assign b       = item_s1.data_byte;
	assign mac_idx = 3'(6'd33 - pos[5:0]);
	assign idx     = len_q - left_q;
	assign is_byte = item_s1.op == dhcp_rfp_pkg::OP_BYTE;

	always_comb begin
		want    = b;
		checked = 1'b1;
		case (pos) inside
			11'd0: want = dhcp_rfp_pkg::BOOTREPLY;
			[11'd4:11'd7]: want = xid_q[{~pos[1:0], 3'b000} +: 8];
			[11'd28:11'd33]: want = mac_q[{mac_idx, 3'b000} +: 8];
			11'd236: want = dhcp_rfp_pkg::COOKIE_0;
			11'd237: want = dhcp_rfp_pkg::COOKIE_1;
			11'd238: want = dhcp_rfp_pkg::COOKIE_2;
			11'd239: want = dhcp_rfp_pkg::COOKIE_3;
			default: checked = 1'b0;
		endcase
	end

	always_comb begin
		offset_n   = offset_q;
		good_n     = good_q;
		phase_n    = phase_q;
		code_n     = code_q;
		len_n      = len_q;
		left_n     = left_q;
		cap_n      = cap_q;
		ptype_n    = ptype_q;
		yiaddr_n   = yiaddr_q;
		pval_n     = pval_q;
		pseen_n    = pseen_q;
		lease_ip_n = lease_ip_q;
		lease_n    = lease_q;
		offer_n    = offer_q;
		ack_n      = ack_q;
		finish     = 1'b0;
		result_n   = result_q;
		result_load = 1'b0;

		if (!is_byte) begin
			lease_ip_n = '0;
			for (int k = 0; k < dhcp_rfp_pkg::NUM_SLOTS; k++) begin
				lease_n[k] = '0;
			end
			offer_n = 1'b0;
			ack_n   = 1'b0;
		end else begin
			if (pos >= dhcp_rfp_pkg::OFFSET_W'(dhcp_rfp_pkg::MAX_LEN)) begin
				good_n = 1'b0;
			end
			if (pos < dhcp_rfp_pkg::OFFSET_W'(dhcp_rfp_pkg::HDR_LEN)) begin
				if (checked && want != b) begin
					good_n = 1'b0;
				end
				if (pos >= 11'd16 && pos <= 11'd19) begin
					yiaddr_n[{pos[1:0], 3'b000} +: 8] = b;
				end
			end else begin
				case (phase_q)
					dhcp_rfp_pkg::PH_CODE: begin
						if (b == dhcp_rfp_pkg::OPT_END) begin
							phase_n = dhcp_rfp_pkg::PH_DONE;
						end else if (b != dhcp_rfp_pkg::OPT_PAD) begin
							code_n  = b;
							phase_n = dhcp_rfp_pkg::PH_LEN;
						end
					end
					dhcp_rfp_pkg::PH_LEN: begin
						len_n  = b;
						left_n = b;
						cap_n  = '0;
						// zero-length option completes at once and sets nothing
						phase_n = (b == 8'd0) ? dhcp_rfp_pkg::PH_CODE : dhcp_rfp_pkg::PH_DATA;
					end
					dhcp_rfp_pkg::PH_DATA: begin
						if (idx < 8'd4) begin
							cap_n[{idx[1:0], 3'b000} +: 8] = b;
						end
						left_n = left_q - 8'd1;
						if (left_n == 8'd0) begin
							finish  = 1'b1;
							phase_n = dhcp_rfp_pkg::PH_CODE;
						end
					end
					default: ;
				endcase
			end

			if (finish) begin
				if (code_q == dhcp_rfp_pkg::OPT_MSG_TYPE) begin
					ptype_n = cap_n[7:0];
				end
				if (len_q >= 8'd4) begin
					case (code_q)
						dhcp_rfp_pkg::OPT_SUBNET: begin
							pval_n[dhcp_rfp_pkg::SLOT_SUBNET]  = cap_n;
							pseen_n[dhcp_rfp_pkg::SLOT_SUBNET] = 1'b1;
						end
						dhcp_rfp_pkg::OPT_ROUTER: begin
							pval_n[dhcp_rfp_pkg::SLOT_ROUTER]  = cap_n;
							pseen_n[dhcp_rfp_pkg::SLOT_ROUTER] = 1'b1;
						end
						dhcp_rfp_pkg::OPT_DNS: begin
							pval_n[dhcp_rfp_pkg::SLOT_DNS]  = cap_n;
							pseen_n[dhcp_rfp_pkg::SLOT_DNS] = 1'b1;
						end
						dhcp_rfp_pkg::OPT_SERVER_ID: begin
							pval_n[dhcp_rfp_pkg::SLOT_SERVER]  = cap_n;
							pseen_n[dhcp_rfp_pkg::SLOT_SERVER] = 1'b1;
						end
						default: ;
					endcase
				end
			end

			if (offset_q != dhcp_rfp_pkg::OFFSET_MAX) begin
				offset_n = offset_q + 1'b1;
			end

			if (item_s1.last) begin
				result_load           = 1'b1;
				result_n.status       = dhcp_rfp_pkg::ST_REJECT;
				result_n.message_type = 8'd0;
				if (pos >= 11'(dhcp_rfp_pkg::HDR_LEN - 1) && good_n) begin
					result_n.message_type = ptype_n;
					result_n.status       = dhcp_rfp_pkg::ST_IGNORED;
					if (ptype_n == dhcp_rfp_pkg::MSG_OFFER
							|| ptype_n == dhcp_rfp_pkg::MSG_ACK) begin
						lease_ip_n = yiaddr_n;
						for (int k = 0; k < dhcp_rfp_pkg::NUM_SLOTS; k++) begin
							if (pseen_n[k]) begin
								lease_n[k] = pval_n[k];
							end
						end
						if (ptype_n == dhcp_rfp_pkg::MSG_OFFER) begin
							offer_n         = 1'b1;
							result_n.status = dhcp_rfp_pkg::ST_OFFER;
						end else begin
							ack_n           = 1'b1;
							result_n.status = dhcp_rfp_pkg::ST_ACK;
						end
					end
				end
				result_n.offered_ip  = lease_ip_n;
				result_n.subnet_mask = lease_n[dhcp_rfp_pkg::SLOT_SUBNET];
				result_n.router_ip   = lease_n[dhcp_rfp_pkg::SLOT_ROUTER];
				result_n.dns_ip      = lease_n[dhcp_rfp_pkg::SLOT_DNS];
				result_n.server_ip   = lease_n[dhcp_rfp_pkg::SLOT_SERVER];
				result_n.have_offer  = offer_n;
				result_n.have_ack    = ack_n;

				// restart packet parser
				offset_n = '0;
				good_n   = 1'b1;
				phase_n  = dhcp_rfp_pkg::PH_CODE;
				code_n   = '0;
				len_n    = '0;
				left_n   = '0;
				cap_n    = '0;
				ptype_n  = '0;
				yiaddr_n = '0;
				for (int k = 0; k < dhcp_rfp_pkg::NUM_SLOTS; k++) begin
					pval_n[k] = '0;
				end
				pseen_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q <= '0;
			mac_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dhcp_rfp_pkg::CFG_XID: xid_q <= cfg_data[31:0];
				dhcp_rfp_pkg::CFG_MAC: mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			good_q     <= 1'b1;
			phase_q    <= dhcp_rfp_pkg::PH_CODE;
			code_q     <= '0;
			len_q      <= '0;
			left_q     <= '0;
			cap_q      <= '0;
			ptype_q    <= '0;
			yiaddr_q   <= '0;
			pseen_q    <= '0;
			lease_ip_q <= '0;
			offer_q    <= 1'b0;
			ack_q      <= 1'b0;
			for (int k = 0; k < dhcp_rfp_pkg::NUM_SLOTS; k++) begin
				pval_q[k]  <= '0;
				lease_q[k] <= '0;
			end
		end else if (advance) begin
			offset_q   <= offset_n;
			good_q     <= good_n;
			phase_q    <= phase_n;
			code_q     <= code_n;
			len_q      <= len_n;
			left_q     <= left_n;
			cap_q      <= cap_n;
			ptype_q    <= ptype_n;
			yiaddr_q   <= yiaddr_n;
			pseen_q    <= pseen_n;
			lease_ip_q <= lease_ip_n;
			offer_q    <= offer_n;
			ack_q      <= ack_n;
			pval_q     <= pval_n;
			lease_q    <= lease_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result_load) begin
			result_q <= result_n;
		end
	end

`ifndef SYNTHESIS
	a_reject_no_type: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == dhcp_rfp_pkg::ST_REJECT
		|-> result_q.message_type == 8'd0)
		else $error("rejected beat carries a message type");

	a_offer_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == dhcp_rfp_pkg::ST_OFFER
		|-> result_q.have_offer)
		else $error("offer committed without offer flag");

	a_ack_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == dhcp_rfp_pkg::ST_ACK
		|-> result_q.have_ack)
		else $error("ack committed without ack flag");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == dhcp_rfp_pkg::OP_BYTE && item_s1.last
		|=> offset_q == '0 && good_q && phase_q == dhcp_rfp_pkg::PH_CODE)
		else $error("parser not restarted after last byte");
`endif

endmodule
`default_nettype wire

// ===== bench/dhcp_reply_filter_parser_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhcp_reply_filter_parser_top_tb
// Self-checking bench for the DHCP reply filter and option parser. A driver
// feeds payload and clear beats from a queue, and a model of the header
// filter, option walk and lease commit predicts each result beat. A monitor
// compares every result field against the oldest prediction. Directed frames
// come first (a full offer, an ack with empty, long, short and cut options,
// a clear mid-packet, short headers). Each register setting then gets its own
// frames: a header fault, an ignored type, and a burst of short frames with
// one long receiver hold-off that backs the block up, then a random frame.
// ----------------------------------------------------------------------------
module dhcp_reply_filter_parser_top_tb;

	localparam logic [7:0] MSG_REQUEST = 8'd3;
	localparam int HOLD_CYCLES = 1500;
	localparam int STUCK_LIMIT = 6000;
	localparam int SHORT_FRAMES = 24;
	localparam int RANDOM_FRAMES = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [47:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	dhcp_rfp_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	dhcp_rfp_pkg::result_t result;

	dhcp_reply_filter_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial forever #6 clk = ~clk;

	// lease model state
	logic [31:0] xid_cfg = '0;
	logic [47:0] mac_cfg = '0;
	logic [dhcp_rfp_pkg::OFFSET_W-1:0] rx_offset = '0;
	bit rx_good = 1'b1;
	dhcp_rfp_pkg::opt_phase_t opt_state = dhcp_rfp_pkg::PH_CODE;
	logic [7:0] opt_code = '0;
	logic [7:0] opt_len = '0;
	logic [7:0] opt_left = '0;
	logic [31:0] opt_cap = '0;
	logic [7:0] rx_type = '0;
	logic [31:0] rx_yiaddr = '0;
	logic [31:0] rx_val [dhcp_rfp_pkg::NUM_SLOTS] = '{default: '0};
	bit rx_seen [dhcp_rfp_pkg::NUM_SLOTS] = '{default: 1'b0};
	logic [31:0] lease_ip = '0;
	logic [31:0] lease_val [dhcp_rfp_pkg::NUM_SLOTS] = '{default: '0};
	bit offer_flag = 1'b0;
	bit ack_flag = 1'b0;

	dhcp_rfp_pkg::result_t lease_reports [$];
	dhcp_rfp_pkg::item_t pending_beats [$];
	logic [7:0] frame [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int fail_count = 0;
	int beats_in = 0;
	int replies_checked = 0;
	int n_offer = 0;
	int n_ack = 0;
	int n_reject = 0;
	int n_ignored = 0;
	int reg_writes = 0;
	dhcp_rfp_pkg::result_t want_rep;

	function automatic void restart_rx();
		rx_offset = '0;
		rx_good = 1'b1;
		opt_state = dhcp_rfp_pkg::PH_CODE;
		opt_code = '0;
		opt_len = '0;
		opt_left = '0;
		opt_cap = '0;
		rx_type = '0;
		rx_yiaddr = '0;
		rx_val = '{default: '0};
		rx_seen = '{default: 1'b0};
	endfunction

	function automatic void header_byte(int pos, logic [7:0] b);
		logic [7:0] want;
		bit checked;
		want = b;
		checked = 1'b1;
		if (pos == 0)
			want = dhcp_rfp_pkg::BOOTREPLY;
		else if (pos >= 4 && pos <= 7)
			want = xid_cfg[8*(7-pos) +: 8];
		else if (pos >= 28 && pos <= 33)
			want = mac_cfg[8*(33-pos) +: 8];
		else if (pos == 236)
			want = dhcp_rfp_pkg::COOKIE_0;
		else if (pos == 237)
			want = dhcp_rfp_pkg::COOKIE_1;
		else if (pos == 238)
			want = dhcp_rfp_pkg::COOKIE_2;
		else if (pos == 239)
			want = dhcp_rfp_pkg::COOKIE_3;
		else
			checked = 1'b0;
		if (checked && want != b)
			rx_good = 1'b0;
		if (pos >= 16 && pos <= 19)
			rx_yiaddr[8*(pos-16) +: 8] = b;
	endfunction

	function automatic void close_option();
		int slot;
		slot = -1;
		if (opt_code == dhcp_rfp_pkg::OPT_MSG_TYPE && opt_len >= 1)
			rx_type = opt_cap[7:0];
		if (opt_len >= 4) begin
			case (opt_code)
				dhcp_rfp_pkg::OPT_SUBNET: slot = dhcp_rfp_pkg::SLOT_SUBNET;
				dhcp_rfp_pkg::OPT_ROUTER: slot = dhcp_rfp_pkg::SLOT_ROUTER;
				dhcp_rfp_pkg::OPT_DNS: slot = dhcp_rfp_pkg::SLOT_DNS;
				dhcp_rfp_pkg::OPT_SERVER_ID: slot = dhcp_rfp_pkg::SLOT_SERVER;
				default: slot = -1;
			endcase
		end
		if (slot >= 0) begin
			rx_val[slot] = opt_cap;
			rx_seen[slot] = 1'b1;
		end
		opt_state = dhcp_rfp_pkg::PH_CODE;
	endfunction

	function automatic void option_step(logic [7:0] b);
		int idx;
		case (opt_state)
			dhcp_rfp_pkg::PH_CODE: begin
				if (b == dhcp_rfp_pkg::OPT_END)
					opt_state = dhcp_rfp_pkg::PH_DONE;
				else if (b != dhcp_rfp_pkg::OPT_PAD) begin
					opt_code = b;
					opt_state = dhcp_rfp_pkg::PH_LEN;
				end
			end
			dhcp_rfp_pkg::PH_LEN: begin
				opt_len = b;
				opt_left = b;
				opt_cap = '0;
				if (b == 8'd0)
					close_option();
				else
					opt_state = dhcp_rfp_pkg::PH_DATA;
			end
			dhcp_rfp_pkg::PH_DATA: begin
				idx = int'(opt_len) - int'(opt_left);
				if (idx < 4)
					opt_cap[8*idx +: 8] = b;
				opt_left = opt_left - 8'd1;
				if (opt_left == 8'd0)
					close_option();
			end
			default: ;
		endcase
	endfunction

	function automatic void track_reply_byte(dhcp_rfp_pkg::item_t beat);
		int pos;
		dhcp_rfp_pkg::result_t rep;
		pos = int'(rx_offset);
		if (beat.op == dhcp_rfp_pkg::OP_CLEAR) begin
			lease_ip = '0;
			lease_val = '{default: '0};
			offer_flag = 1'b0;
			ack_flag = 1'b0;
			return;
		end
		if (pos >= dhcp_rfp_pkg::MAX_LEN)
			rx_good = 1'b0;
		if (pos < dhcp_rfp_pkg::HDR_LEN)
			header_byte(pos, beat.data_byte);
		else
			option_step(beat.data_byte);
		if (rx_offset != dhcp_rfp_pkg::OFFSET_MAX)
			rx_offset = rx_offset + 1'b1;
		if (!beat.last)
			return;
		rep = '0;
		if (pos + 1 < dhcp_rfp_pkg::HDR_LEN || !rx_good) begin
			rep.status = dhcp_rfp_pkg::ST_REJECT;
			n_reject++;
		end else begin
			rep.message_type = rx_type;
			if (rx_type == dhcp_rfp_pkg::MSG_OFFER || rx_type == dhcp_rfp_pkg::MSG_ACK) begin
				lease_ip = rx_yiaddr;
				for (int k = 0; k < dhcp_rfp_pkg::NUM_SLOTS; k++)
					if (rx_seen[k])
						lease_val[k] = rx_val[k];
				if (rx_type == dhcp_rfp_pkg::MSG_OFFER) begin
					offer_flag = 1'b1;
					rep.status = dhcp_rfp_pkg::ST_OFFER;
					n_offer++;
				end else begin
					ack_flag = 1'b1;
					rep.status = dhcp_rfp_pkg::ST_ACK;
					n_ack++;
				end
			end else begin
				rep.status = dhcp_rfp_pkg::ST_IGNORED;
				n_ignored++;
			end
		end
		rep.offered_ip = lease_ip;
		rep.subnet_mask = lease_val[dhcp_rfp_pkg::SLOT_SUBNET];
		rep.router_ip = lease_val[dhcp_rfp_pkg::SLOT_ROUTER];
		rep.dns_ip = lease_val[dhcp_rfp_pkg::SLOT_DNS];
		rep.server_ip = lease_val[dhcp_rfp_pkg::SLOT_SERVER];
		rep.have_offer = offer_flag;
		rep.have_ack = ack_flag;
		lease_reports.push_back(rep);
		restart_rx();
	endfunction

	// frame building
	function automatic void start_reply();
		frame.delete();
		repeat (dhcp_rfp_pkg::HDR_LEN) frame.push_back(8'($urandom));
		frame[0] = dhcp_rfp_pkg::BOOTREPLY;
		for (int i = 0; i < 4; i++)
			frame[4+i] = xid_cfg[8*(3-i) +: 8];
		for (int i = 0; i < 6; i++)
			frame[28+i] = mac_cfg[8*(5-i) +: 8];
		frame[236] = dhcp_rfp_pkg::COOKIE_0;
		frame[237] = dhcp_rfp_pkg::COOKIE_1;
		frame[238] = dhcp_rfp_pkg::COOKIE_2;
		frame[239] = dhcp_rfp_pkg::COOKIE_3;
	endfunction

	function automatic void corrupt_header(int which);
		int pos;
		case (which)
			0: pos = 0;
			1: pos = $urandom_range(7, 4);
			2: pos = $urandom_range(33, 28);
			default: pos = $urandom_range(239, 236);
		endcase
		frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
	endfunction

	function automatic void add_option(logic [7:0] code, int len);
		frame.push_back(code);
		frame.push_back(8'(len));
		repeat (len) frame.push_back(8'($urandom));
	endfunction

	function automatic void add_msg_type(logic [7:0] kind);
		frame.push_back(dhcp_rfp_pkg::OPT_MSG_TYPE);
		frame.push_back(8'd1);
		frame.push_back(kind);
	endfunction

	function automatic void trim_frame(int n);
		while (frame.size() > n)
			void'(frame.pop_back());
	endfunction

	function automatic void push_clear(logic [7:0] d, logic l);
		dhcp_rfp_pkg::item_t beat;
		beat.op = dhcp_rfp_pkg::OP_CLEAR;
		beat.data_byte = d;
		beat.last = l;
		pending_beats.push_back(beat);
	endfunction

	function automatic void send_frame(int clear_at);
		dhcp_rfp_pkg::item_t beat;
		for (int i = 0; i < frame.size(); i++) begin
			if (i == clear_at || $urandom_range(999) < 3)
				push_clear(8'($urandom), 1'($urandom));
			beat.op = dhcp_rfp_pkg::OP_BYTE;
			beat.data_byte = frame[i];
			beat.last = (i == frame.size() - 1);
			pending_beats.push_back(beat);
		end
	endfunction

	function automatic logic [7:0] pick_msg_type();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return dhcp_rfp_pkg::MSG_OFFER;
		else if (r < 90)
			return dhcp_rfp_pkg::MSG_ACK;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_value_code();
		case ($urandom_range(3))
			0: return dhcp_rfp_pkg::OPT_SUBNET;
			1: return dhcp_rfp_pkg::OPT_ROUTER;
			2: return dhcp_rfp_pkg::OPT_DNS;
			default: return dhcp_rfp_pkg::OPT_SERVER_ID;
		endcase
	endfunction

	function automatic void add_random_options();
		int n;
		int r;
		n = $urandom_range(6);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 20)
				add_msg_type(pick_msg_type());
			else if (r < 65)
				add_option(pick_value_code(),
					($urandom_range(3) != 0) ? 4 : $urandom_range(10));
			else if (r < 75)
				repeat ($urandom_range(3, 1)) frame.push_back(dhcp_rfp_pkg::OPT_PAD);
			else if (r < 88)
				add_option(8'($urandom_range(254, 1)), $urandom_range(12));
			else
				add_option(dhcp_rfp_pkg::OPT_MSG_TYPE, $urandom_range(3));
		end
	endfunction

	function automatic void gen_random_frame();
		int r;
		r = $urandom_range(99);
		start_reply();
		if (r < 86) begin
			if (r >= 72)
				corrupt_header($urandom_range(3));
			if ($urandom_range(9) < 8)
				add_msg_type(pick_msg_type());
			add_random_options();
			if ($urandom_range(9) < 7) begin
				frame.push_back(dhcp_rfp_pkg::OPT_END);
				repeat ($urandom_range(8)) frame.push_back(8'($urandom));
			end
			if ($urandom_range(9) == 0)
				trim_frame($urandom_range(frame.size(), dhcp_rfp_pkg::HDR_LEN));
		end else begin
			trim_frame($urandom_range(dhcp_rfp_pkg::HDR_LEN, 1));
		end
		send_frame(-1);
	endfunction

	task automatic write_regs(logic [31:0] xid, logic [47:0] mac);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= dhcp_rfp_pkg::CFG_XID;
		cfg_data <= {16'h0, xid};
		xid_cfg = xid;
		@(posedge clk);
		cfg_index <= dhcp_rfp_pkg::CFG_MAC;
		cfg_data <= mac;
		mac_cfg = mac;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reg_writes += 2;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_beats.size() != 0 || item_valid || lease_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				track_reply_byte(item);
				beats_in++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_beats.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (lease_reports.size() == 0) begin
				$error("result beat with no prediction pending");
				fail_count++;
			end else begin
				want_rep = lease_reports.pop_front();
				check_field("status", 32'(want_rep.status), 32'(result.status));
				check_field("message_type", 32'(want_rep.message_type),
					32'(result.message_type));
				check_field("offered_ip", want_rep.offered_ip, result.offered_ip);
				check_field("subnet_mask", want_rep.subnet_mask, result.subnet_mask);
				check_field("router_ip", want_rep.router_ip, result.router_ip);
				check_field("dns_ip", want_rep.dns_ip, result.dns_ip);
				check_field("server_ip", want_rep.server_ip, result.server_ip);
				check_field("have_offer", 32'(want_rep.have_offer), 32'(result.have_offer));
				check_field("have_ack", 32'(want_rep.have_ack), 32'(result.have_ack));
				replies_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("dhcp_reply_filter_parser_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct <= 12;
		recv_idle_pct <= 60;
		write_regs($urandom, {16'($urandom), 32'($urandom)});

		push_clear(8'hFF, 1'b1);
		push_clear(8'h00, 1'b0);

		// offer with every value and pad bytes; options after the end mark
		start_reply();
		add_msg_type(dhcp_rfp_pkg::MSG_OFFER);
		add_option(dhcp_rfp_pkg::OPT_SUBNET, 4);
		add_option(dhcp_rfp_pkg::OPT_ROUTER, 4);
		frame.push_back(dhcp_rfp_pkg::OPT_PAD);
		frame.push_back(dhcp_rfp_pkg::OPT_PAD);
		add_option(dhcp_rfp_pkg::OPT_DNS, 4);
		add_option(dhcp_rfp_pkg::OPT_SERVER_ID, 4);
		frame.push_back(dhcp_rfp_pkg::OPT_END);
		add_msg_type(dhcp_rfp_pkg::MSG_ACK);
		add_option(dhcp_rfp_pkg::OPT_DNS, 4);
		send_frame(-1);

		// ack with empty, long and short options, a clear inside the packet,
		// and an option cut off inside its data
		start_reply();
		add_option(dhcp_rfp_pkg::OPT_MSG_TYPE, 0);
		add_msg_type(dhcp_rfp_pkg::MSG_ACK);
		add_option(dhcp_rfp_pkg::OPT_ROUTER, 8);
		add_option(dhcp_rfp_pkg::OPT_DNS, 3);
		add_option(dhcp_rfp_pkg::OPT_SUBNET, 1);
		add_option(dhcp_rfp_pkg::OPT_SERVER_ID, 2);
		add_option(dhcp_rfp_pkg::OPT_SUBNET, 4);
		trim_frame(frame.size() - 2);
		send_frame(100);

		start_reply();
		trim_frame(dhcp_rfp_pkg::HDR_LEN - 1);
		send_frame(-1);
		start_reply();
		trim_frame(1);
		send_frame(-1);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: begin
					send_idle_pct <= 12;
					recv_idle_pct <= 60;
					write_regs('0, '0);
					start_reply();
					corrupt_header($urandom_range(3));
					add_msg_type(dhcp_rfp_pkg::MSG_ACK);
					frame.push_back(dhcp_rfp_pkg::OPT_SUBNET);
					send_frame(-1);
				end
				1: begin
					send_idle_pct <= 60;
					recv_idle_pct <= 12;
					write_regs('1, '1);
					// ignored type; a message type cut off before its value
					start_reply();
					add_msg_type(MSG_REQUEST);
					add_option(dhcp_rfp_pkg::OPT_SUBNET, 4);
					frame.push_back(dhcp_rfp_pkg::OPT_MSG_TYPE);
					frame.push_back(8'd1);
					send_frame(-1);
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
					write_regs($urandom, {16'($urandom), 32'($urandom)});
					hold_arm <= 1'b1;
					repeat (SHORT_FRAMES) begin
						start_reply();
						trim_frame($urandom_range(8, 1));
						send_frame(-1);
					end
					repeat (RANDOM_FRAMES) gen_random_frame();
				end
			endcase
		end

		drain();
		repeat (8) @(posedge clk);
		$display("%0d beats in, %0d replies checked: %0d offers, %0d acks, %0d rejected,",
			beats_in, replies_checked, n_offer, n_ack, n_reject);
		$display("%0d ignored; %0d register writes over four settings",
			n_ignored, reg_writes);
		if (fail_count == 0 && lease_reports.size() == 0)
			$display("dhcp_reply_filter_parser_top_tb OK");
		else
			$display("dhcp_reply_filter_parser_top_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
